// ===== rtl/sthit_pkg.sv =====
// sthit_pkg: shared types, constants and control store of sorted_table_interval_hit.
// No dependencies; imported by sthit_ram users and by the top level.
`timescale 1ns / 1ps
`default_nettype none
package sthit_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int CMD_W       = 2;
  localparam int IN_W        = 2 * VAL_W;
  localparam int OUT_RAW_W   = 3 * VAL_W + 2;
  localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t S_FETCH = 3'd0;
  localparam step_t S_SETUP = 3'd1;
  localparam step_t S_PROBE = 3'd2;
  localparam step_t S_STEP  = 3'd3;
  localparam step_t S_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_SETUP,
    OP_PROBE,
    OP_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_QUERY,
    C_DONE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // control store: jump to jmp when cond holds, else go to nxt
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_FETCH: w = '{op: OP_FETCH, cond: C_NO_QUERY, jmp: S_FETCH, nxt: S_SETUP};
      S_SETUP: w = '{op: OP_SETUP, cond: C_NEVER,    jmp: S_FETCH, nxt: S_PROBE};
      S_PROBE: w = '{op: OP_PROBE, cond: C_DONE,     jmp: S_EMIT,  nxt: S_STEP};
      S_STEP:  w = '{op: OP_STEP,  cond: C_ALWAYS,   jmp: S_PROBE, nxt: S_PROBE};
      S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY, jmp: S_EMIT,  nxt: S_FETCH};
      default: w = '{op: OP_FETCH, cond: C_ALWAYS,   jmp: S_FETCH, nxt: S_FETCH};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sthit_ram.sv =====
// sthit_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sthit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_table_interval_hit.sv =====
// sorted_table_interval_hit: top level, microcoded search sequencer and datapath.
// Depends on sthit_pkg (control store, constants) and sthit_ram (value table).
//
// Clear and append transactions give no result. A query runs a lower-bound binary search
// over the loaded entries through one RAM read port: one fetch step, one setup step, two
// steps (probe, compare) per halving of the search range, one last probe and an emit step.
// The emit step waits while the previous result is still held on the master side. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module sorted_table_interval_hit (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [sthit_pkg::IN_W-1:0]  s_tdata,  // value[31:0], bound[63:32]
  input  wire logic [sthit_pkg::CMD_W-1:0] s_tuser,  // cmd[1:0]
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [sthit_pkg::OUT_W-1:0]   m_tdata    // hit[0], low_end[32:1],
                                                   // high_end[64:33], hit_count[96:65],
                                                   // load_dropped[97], zero pad
);
  import sthit_pkg::*;

  step_t  upc, upc_next;
  uword_t uw;
  logic   cond_ok;

  logic [CNT_W-1:0]        entry_count;
  logic [VAL_W-1:0]        hits_so_far;
  logic                    overflow_seen;
  logic [CNT_W-1:0]        lo, hi, mid;
  logic signed [VAL_W-1:0] lo_end, hi_end;
  logic [VAL_W-1:0]        rdata;

  logic                    accepted;
  cmd_t                    cmd;
  logic signed [VAL_W-1:0] in_value, in_bound;
  logic                    table_full;
  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [CNT_W-1:0]        mid_calc;
  logic                    search_done;
  logic                    hit;
  logic [VAL_W-1:0]        hits_inc;

  assign uw         = ucode(upc);
  assign s_tready   = (uw.op == OP_FETCH);
  assign accepted   = s_tvalid && s_tready;
  assign cmd        = s_tuser;
  assign in_value   = s_tdata[VAL_W-1:0];
  assign in_bound   = s_tdata[2*VAL_W-1:VAL_W];
  assign table_full = (entry_count == CNT_W'(TABLE_DEPTH));
  assign ram_we     = accepted && (cmd == CMD_APPEND) && !table_full;

  assign search_done = (lo >= hi);
  assign mid_calc    = lo + ((hi - lo) >> 1);
  assign ram_re      = (uw.op == OP_PROBE);
  assign ram_raddr   = search_done ? lo[ADDR_W-1:0] : mid_calc[ADDR_W-1:0];

  assign hit      = (lo < entry_count) && ($signed(rdata) <= hi_end);
  assign hits_inc = (hit && (hits_so_far != '1)) ? hits_so_far + VAL_W'(1) : hits_so_far;

  always_comb begin
    case (uw.cond)
      C_NEVER:    cond_ok = 1'b0;
      C_ALWAYS:   cond_ok = 1'b1;
      C_NO_QUERY: cond_ok = !(accepted && (cmd == CMD_QUERY));
      C_DONE:     cond_ok = search_done;
      C_OUT_BUSY: cond_ok = m_tvalid && !m_tready;
      default:    cond_ok = 1'b1;
    endcase
    upc_next = cond_ok ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  sthit_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      hits_so_far   <= '0;
      overflow_seen <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if ((uw.op == OP_EMIT) && !cond_ok) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (uw.op)
        OP_FETCH: begin
          if (accepted && (cmd == CMD_CLEAR)) begin
            entry_count <= '0;
            hits_so_far <= '0;
          end
          if (accepted && (cmd == CMD_APPEND)) begin
            if (table_full) begin
              overflow_seen <= 1'b1;
            end else begin
              entry_count <= entry_count + CNT_W'(1);
            end
          end
        end
        OP_EMIT: begin
          if (!cond_ok) begin
            hits_so_far <= hits_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // search datapath and result register
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_SETUP: begin
        lo <= '0;
        hi <= entry_count;
        if (lo_end > hi_end) begin
          lo_end <= hi_end;
          hi_end <= lo_end;
        end
      end
      OP_FETCH: begin
        lo_end <= in_value;
        hi_end <= in_bound;
      end
      OP_PROBE: begin
        mid <= mid_calc;
      end
      OP_STEP: begin
        if ($signed(rdata) < lo_end) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      OP_EMIT: begin
        if (!cond_ok) begin
          m_tdata <= OUT_W'({overflow_seen, hits_inc, hi_end, lo_end, hit});
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    (upc == S_PROBE || upc == S_STEP || upc == S_EMIT) |-> (lo <= hi && hi <= entry_count))
    else $error("search range out of order");

  a_ends_ordered: assert property (@(posedge clk) disable iff (rst)
    (upc == S_PROBE || upc == S_STEP || upc == S_EMIT) |-> (lo_end <= hi_end))
    else $error("interval ends not ordered during search");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("load-dropped flag fell without reset");

  a_emit_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(upc) == S_EMIT)
    else $error("result raised outside emit step");
`endif

endmodule
`default_nettype wire
